@@ rtl/core/drive_transfer_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Drive transfer queue assertion macros
// Concurrent assertion wrappers shared by the drive transfer queue RTL.
// ----------------------------------------------------------------------------
`ifndef DRIVE_TRANSFER_QUEUE_UNIT_DEFINES_SVH
`define DRIVE_TRANSFER_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// checked on every clock edge outside reset
`define DTQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define DTQ_ASSERT_NEXT(lbl, pre, post, msg) \
	`DTQ_ASSERT(lbl, (pre) |=> (post), msg)

`else

`define DTQ_ASSERT(lbl, prop, msg)
`define DTQ_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

@@ rtl/core/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// Drive transfer queue package
// Command and result codes, field widths and the result record.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int CMD_W    = 2;
	localparam int UNIT_W   = 3;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int ATTN_W   = 8;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 64;

	localparam logic [3:0] EMPTY_MARK = 4'b1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_INT     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ATTN  = 2'd2,
		KIND_DUP   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [UNIT_W-1:0]   unit;
		logic [WORD_W-1:0]   status;
		logic [COUNT_W-1:0]  count;
		logic [ATTN_W-1:0]   attn;
		logic                last;
	} res_t;

	function automatic res_t mk_res(kind_t kind, logic [UNIT_W-1:0] unit,
			logic [WORD_W-1:0] status, logic [COUNT_W-1:0] count,
			logic [ATTN_W-1:0] attn, logic last);
		res_t r;
		r.kind   = kind;
		r.unit   = unit;
		r.status = status;
		r.count  = count;
		r.attn   = attn;
		r.last   = last;
		return r;
	endfunction

endpackage

@@ rtl/core/drive_transfer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Drive transfer queue
// Per-adapter FIFO of drive transfer requests, linked through the units.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                 | tuser   | tlast
//  s_axis   | in  | unit, status, byte count, attention   | command | -
//  m_axis   | out | unit, status, count, attention bit    | kind    | last
//
//  Start and restart requests update the queue as they are accepted; a start
//  that launches a unit, or a duplicate start, gives its result from the output
//  register the cycle after. An interrupt walks the attention bits with one index,
//  one unit per cycle while the output is not stalled: up to 1 + UNIT_COUNT results.
//  Nothing new is taken while an interrupt is being reported or while a
//  result is held against a stalled m_axis_tready.
//  Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "drive_transfer_queue_unit_defines.svh"

module drive_transfer_queue_unit #(
	parameter int UNIT_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// unit[2:0], status_word[34:3], byte_count_reg[66:35], attention[74:67]
	input  logic [dtq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// command
	input  logic [dtq_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// unit_out[2:0], status_out[34:3], count_out[50:35], attn_bit[58:51]
	output logic [dtq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// kind
	output logic [1:0]                      m_axis_tuser,
	output logic                            m_axis_tlast
);
	import dtq_pkg::*;

	localparam int IDX_W = (UNIT_COUNT > 2) ? $clog2(UNIT_COUNT) : 1;
	localparam logic [UNIT_COUNT-1:0] ONE_U = UNIT_COUNT'(1);

	typedef enum logic {
		S_IDLE,
		S_INT
	} state_t;

	state_t                state_q;
	res_t                  out_q;
	logic                  out_valid_q;
	res_t                  comp_res_q;
	logic                  comp_q;
	logic                  start_q;
	logic [UNIT_COUNT-1:0] as_q;
	logic [IDX_W-1:0]      idx_q;
	logic [3:0]            head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [3:0]            link_q [UNIT_COUNT];
	logic [UNIT_COUNT-1:0] pending_q;
	logic                  busy_q;

	logic                  slot_free;
	logic                  in_acc;
	cmd_t                  cmd;
	logic [UNIT_W-1:0]     u;
	logic                  u_ok;
	logic [IDX_W-1:0]      ui;
	logic [WORD_W-1:0]     status_in;
	logic [WORD_W-1:0]     bcr_in;
	logic [UNIT_COUNT-1:0] as_in;
	logic                  head_ok;
	logic [IDX_W-1:0]      hi;
	logic [UNIT_COUNT-1:0] head_bit;
	logic                  retire;
	logic [3:0]            new_head;
	logic [UNIT_COUNT-1:0] idx_bit;
	logic [UNIT_COUNT-1:0] as_rest;

	function automatic logic unit_valid(logic [3:0] h);
		return !h[3] && ({1'b0, h[2:0]} < 4'(UNIT_COUNT));
	endfunction

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && slot_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign cmd       = cmd_t'(s_axis_tuser);
	assign u         = s_axis_tdata[2:0];
	assign u_ok      = {1'b0, u} < 4'(UNIT_COUNT);
	assign ui        = u[IDX_W-1:0];
	assign status_in = s_axis_tdata[34:3];
	assign bcr_in    = s_axis_tdata[66:35];
	assign as_in     = s_axis_tdata[67 +: UNIT_COUNT];

	assign head_ok   = unit_valid(head_q);
	assign hi        = head_q[IDX_W-1:0];
	assign head_bit  = ONE_U << hi;
	assign retire    = busy_q && head_ok;
	assign new_head  = retire ? link_q[hi] : head_q;
	assign idx_bit   = ONE_U << idx_q;
	assign as_rest   = as_q & ~idx_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			comp_q      <= 1'b0;
			start_q     <= 1'b0;
			as_q        <= '0;
			idx_q       <= '0;
			head_q      <= EMPTY_MARK;
			tail_q      <= '0;
			pending_q   <= '0;
			busy_q      <= 1'b0;
			for (int i = 0; i < UNIT_COUNT; i++) begin
				link_q[i] <= EMPTY_MARK;
			end
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							CMD_START: begin
								if (u_ok) begin
									if (pending_q[ui]) begin
										out_q       <= mk_res(KIND_DUP, u, '0, '0, '0, 1'b1);
										out_valid_q <= 1'b1;
									end else begin
										if (!head_ok) begin
											head_q <= {1'b0, u};
										end else begin
											link_q[tail_q] <= {1'b0, u};
										end
										tail_q        <= ui;
										link_q[ui]    <= EMPTY_MARK;
										pending_q[ui] <= 1'b1;
										if (!busy_q) begin
											busy_q      <= 1'b1;
											out_q       <= mk_res(KIND_START,
												head_ok ? head_q[2:0] : u, '0, '0, '0, 1'b1);
											out_valid_q <= 1'b1;
										end
									end
								end
							end
							CMD_INT: begin
								head_q  <= new_head;
								busy_q  <= unit_valid(new_head);
								start_q <= unit_valid(new_head);
								comp_q  <= retire;
								idx_q   <= '0;
								if (retire) begin
									pending_q  <= pending_q & ~head_bit;
									as_q       <= as_in & ~head_bit;
									comp_res_q <= mk_res(KIND_DONE, head_q[2:0], status_in,
										COUNT_W'(-bcr_in), ATTN_W'(as_in & head_bit), 1'b0);
								end else begin
									as_q <= as_in;
								end
								state_q <= S_INT;
							end
							CMD_RESTART: begin
								if (u_ok) begin
									busy_q     <= 1'b1;
									link_q[ui] <= head_q;
									head_q     <= {1'b0, u};
								end
							end
							default: ;
						endcase
					end
				end
				S_INT: begin
					if (slot_free) begin
						priority if (comp_q) begin
							out_q       <= mk_res(comp_res_q.kind, comp_res_q.unit,
								comp_res_q.status, comp_res_q.count, comp_res_q.attn,
								(as_q == '0) && !start_q);
							out_valid_q <= 1'b1;
							comp_q      <= 1'b0;
						end else if (as_q != '0) begin
							if (as_q[idx_q]) begin
								out_q       <= mk_res(KIND_ATTN, UNIT_W'(idx_q), '0, '0,
									ATTN_W'(idx_bit), (as_rest == '0) && !start_q);
								out_valid_q <= 1'b1;
								as_q        <= as_rest;
							end
							idx_q <= idx_q + 1'b1;
						end else if (start_q) begin
							out_q       <= mk_res(KIND_START, head_q[2:0], '0, '0, '0, 1'b1);
							out_valid_q <= 1'b1;
							start_q     <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.attn, out_q.count, out_q.status, out_q.unit};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

	// an idle adapter never holds a queued unit
	`DTQ_ASSERT(a_idle_empty, (state_q == S_IDLE && !busy_q) |-> head_q[3], "idle with queued unit")
	// an accepted interrupt always enters the report sequence
	`DTQ_ASSERT_NEXT(a_int_seq, in_acc && s_axis_tuser == CMD_INT, state_q == S_INT, "interrupt not sequenced")
	// a pending completion only exists while reporting
	`DTQ_ASSERT(a_comp_in_int, (comp_q || start_q) |-> (state_q == S_INT), "stray completion or start")

endmodule

@@ verif/tb_drive_transfer_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive transfer queue testbench
// Drives start, interrupt, restart and unknown requests into the queue and checks
// every result against an in-bench queue model, under varying idle, stall
// and back-pressure patterns on both streams.
// ----------------------------------------------------------------------------
module tb_drive_transfer_queue_unit;

	import dtq_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int HOLD_CYCLES      = 300;
	localparam int SETTLE_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT   = 3000;

	// queue model and expected-result store
	class dtq_scoreboard;
		res_t        expected_q[$];
		logic [3:0]  head;
		logic [2:0]  tail;
		logic [3:0]  link[8];
		logic [7:0]  pending;
		bit          busy;
		int          mismatches;
		int          requests;
		int          kind_count[4];

		function new();
			head = EMPTY_MARK;
			tail = '0;
			foreach (link[i]) link[i] = EMPTY_MARK;
			pending = '0;
			busy = 1'b0;
			mismatches = 0;
			requests = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function void push(kind_t k, logic [2:0] u, logic [31:0] st, logic [15:0] cnt,
				logic [7:0] ab);
			res_t r;
			r.kind   = k;
			r.unit   = u;
			r.status = st;
			r.count  = cnt;
			r.attn   = ab;
			r.last   = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void launch_head();
			if (!head[3]) begin
				busy = 1'b1;
				push(KIND_START, head[2:0], '0, '0, '0);
			end
		endfunction

		function void note_request(logic [1:0] cmd, logic [2:0] u, logic [31:0] st,
				logic [31:0] bcr, logic [7:0] attn);
			int          before_n;
			logic [7:0]  as;
			logic [2:0]  h;
			logic [31:0] neg;
			res_t        r;
			before_n = expected_q.size();
			as = attn;
			requests++;
			case (cmd)
				CMD_START: begin
					if (pending[u]) begin
						push(KIND_DUP, u, '0, '0, '0);
					end else begin
						if (head[3])
							head = {1'b0, u};
						else
							link[tail] = {1'b0, u};
						tail = u;
						link[u] = EMPTY_MARK;
						pending[u] = 1'b1;
						if (!busy)
							launch_head();
					end
				end
				CMD_INT: begin
					if (busy) begin
						busy = 1'b0;
						if (!head[3]) begin
							h = head[2:0];
							pending[h] = 1'b0;
							head = link[h];
							neg = 32'd0 - bcr;
							push(KIND_DONE, h, st, neg[15:0], as & (8'd1 << h));
							as[h] = 1'b0;
						end
					end
					for (int i = 0; i < 8; i++)
						if (as[i])
							push(KIND_ATTN, 3'(i), '0, '0, 8'd1 << i);
					if (!busy)
						launch_head();
				end
				CMD_RESTART: begin
					busy = 1'b1;
					link[u] = head;
					head = {1'b0, u};
				end
				default: ;
			endcase
			if (expected_q.size() > before_n) begin
				r = expected_q.pop_back();
				r.last = 1'b1;
				expected_q.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d unit %0d", got.kind, got.unit));
			end else begin
				want = expected_q.pop_front();
				kind_count[want.kind]++;
				if (got.kind !== want.kind)
					report($sformatf("kind %0d, want %0d", got.kind, want.kind));
				if (got.unit !== want.unit)
					report($sformatf("unit %0d, want %0d", got.unit, want.unit));
				if (got.status !== want.status)
					report($sformatf("status %h, want %h", got.status, want.status));
				if (got.count !== want.count)
					report($sformatf("count %h, want %h", got.count, want.count));
				if (got.attn !== want.attn)
					report($sformatf("attn %h, want %h", got.attn, want.attn));
				if (got.last !== want.last)
					report($sformatf("last %b, want %b", got.last, want.last));
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	int  src_idle_pct = 0;
	int  snk_stall_pct = 0;
	bit  pressure_on = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;

	dtq_scoreboard sb = new();

	drive_transfer_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (pressure_on && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// monitor: results first, then the request taken on the same edge
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind   = kind_t'(m_axis_tuser);
				got.unit   = m_axis_tdata[2:0];
				got.status = m_axis_tdata[34:3];
				got.count  = m_axis_tdata[50:35];
				got.attn   = m_axis_tdata[58:51];
				got.last   = m_axis_tlast;
				sb.check_result(got);
			end
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[34:3],
						s_axis_tdata[66:35], s_axis_tdata[74:67]);
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout, %0d results outstanding", sb.expected_q.size());
				$display("tb_drive_transfer_queue_unit: errors");
				$finish;
			end
		end
	end

	task send_request(logic [1:0] cmd, logic [2:0] u, logic [31:0] st, logic [31:0] bcr,
			logic [7:0] attn);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, attn, bcr, st, u};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task random_request();
		int          pick;
		logic [1:0]  cmd;
		logic [31:0] bcr;
		logic [7:0]  attn;
		pick = $urandom_range(99);
		if (pick < 55)
			cmd = CMD_START;
		else if (pick < 88)
			cmd = CMD_INT;
		else if (pick < 94)
			cmd = CMD_RESTART;
		else
			cmd = CMD_UNKNOWN;
		if ($urandom_range(1))
			bcr = $urandom;
		else
			bcr = 32'd0 - $urandom_range(1, 65535);
		case ($urandom_range(3))
			0, 1: attn = '0;
			2: attn = 8'd1 << $urandom_range(7);
			default: attn = 8'($urandom);
		endcase
		send_request(cmd, 3'($urandom_range(7)), $urandom, bcr, attn);
	endtask

	// sender holds off until every expected result has arrived
	task drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, idle interrupt, restart and a looped list
		send_request(CMD_START, 3'd0, 32'h0, 32'h0, 8'h00);
		send_request(CMD_START, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
		send_request(CMD_START, 3'd3, 32'h0, 32'h0, 8'h00);
		send_request(CMD_START, 3'd0, 32'h0, 32'h0, 8'h00);
		send_request(CMD_UNKNOWN, 3'd5, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
		send_request(CMD_INT, 3'd0, 32'hffff_ffff, 32'd1, 8'hff);
		send_request(CMD_INT, 3'd0, 32'h0, 32'h0, 8'h80);
		send_request(CMD_INT, 3'd0, 32'ha5a5_5a5a, 32'hffff_ffff, 8'h00);
		send_request(CMD_INT, 3'd0, 32'h5a5a_a5a5, 32'h8000_0000, 8'h81);
		send_request(CMD_RESTART, 3'd5, 32'h0, 32'h0, 8'h00);
		send_request(CMD_INT, 3'd7, 32'hffff_0000, 32'h0001_0000, 8'h20);
		send_request(CMD_START, 3'd4, 32'h0, 32'h0, 8'h00);
		send_request(CMD_START, 3'd6, 32'h0, 32'h0, 8'h00);
		send_request(CMD_RESTART, 3'd6, 32'h0, 32'h0, 8'h00);
		send_request(CMD_INT, 3'd0, 32'h0000_ffff, 32'hffff_fe00, 8'h40);
		send_request(CMD_INT, 3'd0, 32'h1234_5678, 32'h7fff_ffff, 8'h10);
		send_request(CMD_START, 3'd4, 32'h0, 32'h0, 8'h00);
		send_request(CMD_INT, 3'd0, 32'h0, 32'hffff_8000, 8'h00);
		send_request(CMD_INT, 3'd0, 32'h0, 32'h0, 8'h00);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  pressure_on = 1'b1; end
				1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
				default: begin src_idle_pct = 25; snk_stall_pct = 25; end
			endcase
			repeat (RANDOM_PER_PHASE)
				random_request();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests; results: %0d start, %0d done, %0d attention, %0d duplicate",
				sb.requests, sb.kind_count[KIND_START], sb.kind_count[KIND_DONE],
				sb.kind_count[KIND_ATTN], sb.kind_count[KIND_DUP]);
		$display("idle/stall phases run, with one long output hold-off");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb_drive_transfer_queue_unit: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
					sb.expected_q.size());
			$display("tb_drive_transfer_queue_unit: errors");
		end
		$finish;
	end

endmodule
